// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file.
// Each macro wraps one clocked implication with a reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fbpe_pkg.sv =====
// Package for the framebuffer pixel engine: widths, codes and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fbpe_pkg;

  localparam int MAX_WIDTH_DEF   = 512;
  localparam int MAX_HEIGHT_DEF  = 512;
  localparam int FRAME_BYTES_DEF = 1048576;

  localparam int DIM_W    = 10;  // image and rectangle dimensions
  localparam int COORD_W  = 9;   // pixel coordinates
  localparam int PIX_W    = 24;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 2;   // config register index
  localparam int STRIDE_W = 12;  // 3 * 1023 rounded up to 4
  localparam int ROWB_W   = STRIDE_W + DIM_W;
  localparam int COL_W    = 11;  // column byte offset plus lane
  localparam int ADDR_W   = 25;  // covers any store size up to 2^24 bytes

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_GET  = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_POS     = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERRUN = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNSUP   = 2'd3;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_PIXEL_MODE   = 2'd2;

  localparam logic [DIM_W-1:0]    DIM_MIN     = 10'd4;
  localparam logic [DIM_W-1:0]    DIM_RESET   = 10'd4;
  localparam logic [STRIDE_W-1:0] STRIDE_PAD  = 12'h003;
  localparam logic [STRIDE_W-1:0] STRIDE_MASK = ~12'h003;

  localparam logic [1:0] LANE_FIRST = 2'd0;
  localparam logic [1:0] LANE_LAST  = 2'd2;

  typedef struct packed {
    logic       load;      // latch the accepted item
    logic       check;     // bounds checks, row index, stride
    logic       mul;       // row base address, fill counters
    logic       pix_acc;   // one byte access of put/get
    logic [1:0] lane;      // byte lane of pix_acc
    logic       fill_acc;  // one byte write of a fill
    logic       out_load;  // move result into the output register
  } fbpe_cmd_t;

  typedef struct packed {
    logic err;         // status is not ok
    logic is_fill;
    logic is_get;
    logic fill_empty;
    logic fill_last;   // current fill byte is the last one
    logic wide;        // three bytes per pixel
    logic out_free;    // output register can take a result
  } fbpe_sts_t;

endpackage

// ===== hw/rtl/fbpe_ctrl.sv =====
// Controller of the framebuffer pixel engine: one-hot sequencer that
// steps one item through check, address, byte accesses and result. Uses fbpe_pkg.
`timescale 1ns / 1ps

module fbpe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fbpe_pkg::fbpe_sts_t sts,
  output fbpe_pkg::fbpe_cmd_t cmd
);
  import fbpe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_PIX   = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t     state, state_next;
  logic [1:0] lane, lane_next;
  logic       lane_last;

  assign in_stall  = (state != S_IDLE);
  assign lane_last = sts.wide ? (lane == LANE_LAST) : (lane == LANE_FIRST);

  always_comb begin
    state_next = state;
    lane_next  = lane;
    cmd        = '0;
    cmd.lane   = lane;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        lane_next = LANE_FIRST;
        if (sts.err) begin
          state_next = S_DONE;
        end else if (sts.is_fill) begin
          state_next = sts.fill_empty ? S_DONE : S_FILL;
        end else begin
          state_next = S_PIX;
        end
      end
      S_PIX: begin
        cmd.pix_acc = 1'b1;
        if (lane_last) begin
          lane_next  = LANE_FIRST;
          state_next = sts.is_get ? S_DRAIN : S_DONE;
        end else begin
          lane_next = lane + 2'd1;
        end
      end
      S_FILL: begin
        cmd.fill_acc = 1'b1;
        if (sts.fill_last) begin
          state_next = S_DONE;
        end
      end
      S_DRAIN: begin
        // last read byte lands in the result this cycle
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lane  <= LANE_FIRST;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

endmodule

// ===== hw/rtl/fbpe_dp.sv =====
// Datapath of the framebuffer pixel engine: config registers, bounds checks,
// address arithmetic, the byte frame store and the output register. Uses fbpe_pkg.
`timescale 1ns / 1ps

module fbpe_dp #(
  parameter int MAX_WIDTH   = fbpe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = fbpe_pkg::MAX_HEIGHT_DEF,
  parameter int FRAME_BYTES = fbpe_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [fbpe_pkg::IDX_W-1:0]      cfg_index,
  input  logic [fbpe_pkg::DIM_W-1:0]      cfg_data,
  input  logic [fbpe_pkg::OP_W-1:0]       opcode,
  input  logic [fbpe_pkg::COORD_W-1:0]    pos_x,
  input  logic [fbpe_pkg::COORD_W-1:0]    pos_y,
  input  logic [fbpe_pkg::PIX_W-1:0]      pixel_value,
  input  logic [fbpe_pkg::DIM_W-1:0]      fill_width,
  input  logic [fbpe_pkg::DIM_W-1:0]      fill_height,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [fbpe_pkg::STAT_W-1:0]     status,
  output logic [fbpe_pkg::PIX_W-1:0]      read_value,
  input  fbpe_pkg::fbpe_cmd_t             cmd,
  output fbpe_pkg::fbpe_sts_t             sts
);
  import fbpe_pkg::*;

  localparam int MEM_AW  = $clog2(FRAME_BYTES);
  localparam int DIM_TOP = (1 << DIM_W) - 1;
  localparam int WMAX_I  = (MAX_WIDTH > DIM_TOP) ? DIM_TOP : MAX_WIDTH;
  localparam int HMAX_I  = (MAX_HEIGHT > DIM_TOP) ? DIM_TOP : MAX_HEIGHT;
  localparam logic [DIM_W-1:0]  WMAX       = DIM_W'(WMAX_I);
  localparam logic [DIM_W-1:0]  HMAX       = DIM_W'(HMAX_I);
  localparam logic [ADDR_W-1:0] STORE_SIZE = ADDR_W'(FRAME_BYTES);

  // configuration
  logic [DIM_W-1:0] image_width, image_height;
  logic             pixel_mode;

  // latched item
  logic [OP_W-1:0]    op_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [PIX_W-1:0]   val_r;
  logic [DIM_W-1:0]   fw_r, fh_r;

  logic [STAT_W-1:0]   status_r;
  logic [DIM_W-1:0]    row_idx;
  logic [STRIDE_W-1:0] stride_r;
  logic [ADDR_W-1:0]   rowbase;
  logic [DIM_W-1:0]    fill_column, fill_row;
  logic [PIX_W-1:0]    rv;

  logic [7:0]  mem [FRAME_BYTES];
  logic [7:0]  rdata;
  logic        rd_pend, rd_inr;
  logic [1:0]  rd_lane;

  logic [DIM_W-1:0]    w_c, h_c;
  logic [STRIDE_W-1:0] row_bytes, stride;
  logic                pos_bad, overrun;
  logic [STAT_W-1:0]   status_chk;
  logic [ROWB_W-1:0]   prod;
  logic [COL_W-1:0]    xoff, col_term;
  logic [ADDR_W-1:0]   addr;
  logic                addr_inr, acc, wr;
  logic [7:0]          wdata;
  logic                col_end, row_end;

  // dimensions saturated into the supported range
  always_comb begin
    if (image_width < DIM_MIN) w_c = DIM_MIN;
    else if (image_width > WMAX) w_c = WMAX;
    else w_c = image_width;
    if (image_height < DIM_MIN) h_c = DIM_MIN;
    else if (image_height > HMAX) h_c = HMAX;
    else h_c = image_height;
  end

  assign row_bytes = pixel_mode ? ({2'b0, w_c} + {1'b0, w_c, 1'b0}) : {2'b0, w_c};
  assign stride    = (row_bytes + STRIDE_PAD) & STRIDE_MASK;

  assign pos_bad = ({1'b0, x_r} >= w_c) || ({1'b0, y_r} >= h_c);
  assign overrun = (({2'b0, x_r} + {1'b0, fw_r}) > {1'b0, w_c}) ||
                   (({2'b0, y_r} + {1'b0, fh_r}) > {1'b0, h_c});

  always_comb begin
    case (op_r)
      OP_PUT, OP_GET: status_chk = pos_bad ? ST_POS : ST_OK;
      OP_FILL: begin
        if (pos_bad) status_chk = ST_POS;
        else if (overrun) status_chk = ST_OVERRUN;
        else if (pixel_mode) status_chk = ST_UNSUP;
        else status_chk = ST_OK;
      end
      default: status_chk = ST_UNSUP;
    endcase
  end

  assign prod = {{DIM_W{1'b0}}, stride_r} * {{STRIDE_W{1'b0}}, row_idx};

  // byte address of the current access
  assign xoff     = pixel_mode ? ({2'b0, x_r} + {1'b0, x_r, 1'b0}) : {2'b0, x_r};
  assign col_term = cmd.fill_acc ? {1'b0, fill_column} : (xoff + {{(COL_W-2){1'b0}}, cmd.lane});
  assign addr     = rowbase + {{(ADDR_W-COL_W){1'b0}}, col_term};
  assign addr_inr = (addr < STORE_SIZE);
  assign acc      = cmd.pix_acc || cmd.fill_acc;
  assign wr       = cmd.fill_acc || (cmd.pix_acc && (op_r == OP_PUT));

  always_comb begin
    case (cmd.lane)
      2'd1:    wdata = val_r[15:8];
      2'd2:    wdata = val_r[23:16];
      default: wdata = val_r[7:0];
    endcase
    if (cmd.fill_acc) wdata = val_r[7:0];
  end

  assign col_end = (({1'b0, fill_column} + 11'd1) == ({2'b0, x_r} + {1'b0, fw_r}));
  assign row_end = (({1'b0, fill_row} + 11'd1) == ({2'b0, y_r} + {1'b0, fh_r}));

  assign sts.err        = (status_r != ST_OK);
  assign sts.is_fill    = (op_r == OP_FILL);
  assign sts.is_get     = (op_r == OP_GET);
  assign sts.fill_empty = (fw_r == '0) || (fh_r == '0);
  assign sts.fill_last  = col_end && row_end;
  assign sts.wide       = pixel_mode;
  assign sts.out_free   = !out_valid || !out_stall;

  // frame store
  always_ff @(posedge clk) begin
    if (acc) begin
      if (wr && addr_inr) begin
        mem[addr[MEM_AW-1:0]] <= wdata;
      end
      rdata <= mem[addr[MEM_AW-1:0]];
    end
  end

  // configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_RESET;
      image_height <= DIM_RESET;
      pixel_mode   <= 1'b0;
      fill_column  <= '0;
      fill_row     <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          REG_PIXEL_MODE:   pixel_mode   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.mul && (op_r == OP_FILL)) begin
        fill_column <= {1'b0, x_r};
        fill_row    <= {1'b0, y_r};
      end else if (cmd.fill_acc) begin
        if (col_end) begin
          // walker returns to zero after the last row
          fill_column <= row_end ? '0 : {1'b0, x_r};
          fill_row    <= row_end ? '0 : fill_row + 10'd1;
        end else begin
          fill_column <= fill_column + 10'd1;
        end
      end
      rd_pend <= cmd.pix_acc && (op_r == OP_GET);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // item, address and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      x_r   <= pos_x;
      y_r   <= pos_y;
      val_r <= pixel_value;
      fw_r  <= fill_width;
      fh_r  <= fill_height;
      rv    <= '0;
    end
    if (cmd.check) begin
      status_r <= status_chk;
      row_idx  <= h_c - {1'b0, y_r} - 10'd1;  // bottom-up row order
      stride_r <= stride;
    end
    if (cmd.mul) begin
      rowbase <= {{(ADDR_W-ROWB_W){1'b0}}, prod};
    end else if (cmd.fill_acc && col_end) begin
      rowbase <= rowbase - {{(ADDR_W-STRIDE_W){1'b0}}, stride_r};
    end
    if (cmd.pix_acc) begin
      rd_lane <= cmd.lane;
      rd_inr  <= addr_inr;
    end
    if (rd_pend) begin
      case (rd_lane)
        2'd1:    rv[15:8]  <= rd_inr ? rdata : 8'd0;
        2'd2:    rv[23:16] <= rd_inr ? rdata : 8'd0;
        default: rv[7:0]   <= rd_inr ? rdata : 8'd0;
      endcase
    end
    if (cmd.out_load) begin
      status     <= status_r;
      read_value <= rv;
    end
  end

endmodule

// ===== hw/rtl/bottom_up_framebuffer_pixel_engine.sv =====
// Top level of the framebuffer pixel engine: joins controller and datapath.
// Depends on fbpe_pkg, fbpe_ctrl and fbpe_dp.
//
// Usage:
//   Commands enter on in_valid/in_stall (opcode, pos_x, pos_y, pixel_value,
//   fill_width, fill_height); each gives exactly one result on
//   out_valid/out_stall (status, read_value). Image size and pixel mode are
//   written through cfg_write/cfg_index/cfg_data while the engine is idle.
//   The frame store is one byte-wide single-port memory, so the engine runs
//   one item at a time; in_stall is high from acceptance until the result
//   enters the output register.
//   Per item, up to the result register: check and address, then the result
//   at once on any error or empty fill; else one byte access per pixel byte
//   (a get adds a drain step for its registered read), or a fill's width *
//   height bytes, one per cycle. The next item is taken the cycle after.
//   out_valid rises with the result register load; a result
//   held by out_stall does not block acceptance of the next item, which
//   waits at its final step only while the held result is still not taken.
//   Reset clears configuration to 4 x 4, 8-bit mode and empties the output
//   register; the frame store is not cleared and must be written before read.
`timescale 1ns / 1ps

module bottom_up_framebuffer_pixel_engine #(
  parameter int MAX_WIDTH   = fbpe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = fbpe_pkg::MAX_HEIGHT_DEF,
  parameter int FRAME_BYTES = fbpe_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fbpe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fbpe_pkg::DIM_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fbpe_pkg::OP_W-1:0]    opcode,
  input  logic [fbpe_pkg::COORD_W-1:0] pos_x,
  input  logic [fbpe_pkg::COORD_W-1:0] pos_y,
  input  logic [fbpe_pkg::PIX_W-1:0]   pixel_value,
  input  logic [fbpe_pkg::DIM_W-1:0]   fill_width,
  input  logic [fbpe_pkg::DIM_W-1:0]   fill_height,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fbpe_pkg::STAT_W-1:0]  status,
  output logic [fbpe_pkg::PIX_W-1:0]   read_value
);
  import fbpe_pkg::*;

  fbpe_cmd_t cmd;
  fbpe_sts_t sts;

  fbpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbpe_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pixel_value (pixel_value),
    .fill_width  (fill_width),
    .fill_height (fill_height),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .status      (status),
    .read_value  (read_value),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== hw/rtl/fbpe_checker.sv =====
// Port-level checks for the framebuffer pixel engine, bound to the top level.
// Depends on fbpe_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbpe_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [fbpe_pkg::STAT_W-1:0]  status,
  input logic [fbpe_pkg::PIX_W-1:0]   read_value
);
  import fbpe_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")

  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(status) && $stable(read_value), "stalled result changed")

  // one item in flight: acceptance closes the input side
  `ASSERT_NEXT(a_one_item, clk, rst, in_valid && !in_stall, in_stall, "second item taken while busy")

  // failed commands never return pixel data
  `ASSERT_IMPL(a_err_zero, clk, rst, out_valid && (status != ST_OK), read_value == '0, "read data on error")

endmodule

bind bottom_up_framebuffer_pixel_engine fbpe_checker u_fbpe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .read_value (read_value)
);

// ===== bench/pixel_engine_checker.sv =====
// Checker for the framebuffer pixel engine: follows register writes and accepted items,
// keeps its own copy of the frame bytes and compares each result. Depends on fbpe_pkg.
`timescale 1ns / 1ps

module pixel_engine_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [fbpe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fbpe_pkg::DIM_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [fbpe_pkg::OP_W-1:0]    opcode,
  input  logic [fbpe_pkg::COORD_W-1:0] pos_x,
  input  logic [fbpe_pkg::COORD_W-1:0] pos_y,
  input  logic [fbpe_pkg::PIX_W-1:0]   pixel_value,
  input  logic [fbpe_pkg::DIM_W-1:0]   fill_width,
  input  logic [fbpe_pkg::DIM_W-1:0]   fill_height,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [fbpe_pkg::STAT_W-1:0]  status,
  input  logic [fbpe_pkg::PIX_W-1:0]   read_value,
  output int                           mismatches,
  output int                           pending
);
  import fbpe_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PIX_W-1:0]  value;
  } reply_t;

  bit [7:0]          frame [FRAME_BYTES_DEF];
  logic [DIM_W-1:0]  img_w = DIM_RESET;
  logic [DIM_W-1:0]  img_h = DIM_RESET;
  bit                wide = 1'b0;
  reply_t            replies_due[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches = mismatches + 1;
  endtask

  function automatic int unsigned visible(input int unsigned v, input int unsigned hi);
    if (v < DIM_MIN) return 32'(DIM_MIN);
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void poke(input int unsigned addr, input logic [7:0] b);
    if (addr < FRAME_BYTES_DEF) frame[addr] = b;
  endfunction

  function automatic logic [7:0] peek(input int unsigned addr);
    if (addr < FRAME_BYTES_DEF) return frame[addr];
    return 8'd0;
  endfunction

  function automatic reply_t execute_command(input logic [OP_W-1:0] op,
                                             input int unsigned x, y,
                                             input logic [PIX_W-1:0] val,
                                             input int unsigned fw, fh);
    int unsigned w, h, bpp, stride, base;
    reply_t rep;
    w = visible(32'(img_w), MAX_WIDTH_DEF);
    h = visible(32'(img_h), MAX_HEIGHT_DEF);
    bpp = wide ? 3 : 1;
    // row bytes padded up to a whole word
    stride = ((bpp * w) + 3) & ~32'd3;
    rep = '0;
    rep.status = ST_OK;
    if (op != OP_PUT && op != OP_GET && op != OP_FILL) begin
      rep.status = ST_UNSUP;
    end else if (x >= w || y >= h) begin
      rep.status = ST_POS;
    end else if (op != OP_FILL) begin
      // bottom-up: image row 0 is the last stored row
      base = stride * (h - y - 1) + x * bpp;
      if (op == OP_PUT) begin
        poke(base, val[7:0]);
        if (wide) begin
          poke(base + 1, val[15:8]);
          poke(base + 2, val[23:16]);
        end
      end else if (wide) begin
        rep.value = {peek(base + 2), peek(base + 1), peek(base)};
      end else begin
        rep.value = {16'd0, peek(base)};
      end
    end else if (x + fw > w || y + fh > h) begin
      rep.status = ST_OVERRUN;
    end else if (wide) begin
      rep.status = ST_UNSUP;
    end else begin
      for (int unsigned r = y; r < y + fh; r++)
        for (int unsigned c = x; c < x + fw; c++)
          poke(stride * (h - r - 1) + c, val[7:0]);
    end
    return rep;
  endfunction

  always @(posedge clk) begin : watch
    reply_t due;
    if (rst) begin
      img_w = DIM_RESET;
      img_h = DIM_RESET;
      wide = 1'b0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result with none due: status %0d value %06h",
                                    status, read_value));
        end else begin
          due = replies_due.pop_front();
          if (status !== due.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, due.status));
          if (read_value !== due.value)
            report_mismatch($sformatf("read_value %06h, expected %06h",
                                      read_value, due.value));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_w = cfg_data;
          REG_IMAGE_HEIGHT: img_h = cfg_data;
          REG_PIXEL_MODE:   wide = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        replies_due.push_back(execute_command(opcode, 32'(pos_x), 32'(pos_y), pixel_value,
                                              32'(fill_width), 32'(fill_height)));
    end
    pending = replies_due.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the pixel engine bench: clock, reset, register setup and command stimulus,
// with random stalls on the result side. Depends on fbpe_pkg and pixel_engine_checker.
`timescale 1ns / 1ps

module testbench;
  import fbpe_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [OP_W-1:0]  OP_UNKNOWN = 2'd3;
  localparam logic [IDX_W-1:0] REG_SPARE  = 2'd3;

  typedef struct {
    int x;
    int y;
  } spot_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [IDX_W-1:0]   cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    opcode = OP_PUT;
  logic [COORD_W-1:0] pos_x = '0;
  logic [COORD_W-1:0] pos_y = '0;
  logic [PIX_W-1:0]   pixel_value = '0;
  logic [DIM_W-1:0]   fill_width = '0;
  logic [DIM_W-1:0]   fill_height = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STAT_W-1:0]  status;
  logic [PIX_W-1:0]   read_value;

  int mismatches;
  int pending;
  int cycles = 0;
  int stall_left = 0;
  bit idling = 1'b1;

  // image as the engine sees it, and pixels written under the present setup
  int img_w_eff = 32'(DIM_RESET);
  int img_h_eff = 32'(DIM_RESET);
  bit wide = 1'b0;
  bit [MAX_WIDTH_DEF-1:0] painted_map [MAX_HEIGHT_DEF];
  spot_t painted[$];

  always #10 clk = ~clk;

  bottom_up_framebuffer_pixel_engine DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .pixel_value(pixel_value),
    .fill_width(fill_width), .fill_height(fill_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value)
  );

  pixel_engine_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .pixel_value(pixel_value),
    .fill_width(fill_width), .fill_height(fill_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value),
    .mismatches(mismatches), .pending(pending)
  );

  // result side stalls in random bursts, started only while idling is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bottom_up_framebuffer_pixel_engine verification failed");
      $finish;
    end
  end

  function automatic int visible(input int v);
    if (v < DIM_MIN) return 32'(DIM_MIN);
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  task automatic paint(input int x, y);
    if (!painted_map[y][x]) begin
      painted_map[y][x] = 1'b1;
      painted.push_back('{x, y});
    end
  endtask

  // one item; returns at the edge that accepts it
  task automatic issue(input logic [OP_W-1:0] op, input int x, y,
                       input logic [PIX_W-1:0] val, input int fw, fh);
    int gap;
    gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    pos_x <= x[COORD_W-1:0];
    pos_y <= y[COORD_W-1:0];
    pixel_value <= val;
    fill_width <= fw[DIM_W-1:0];
    fill_height <= fh[DIM_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (x < img_w_eff && y < img_h_eff) begin
      if (op == OP_PUT) begin
        paint(x, y);
      end else if (op == OP_FILL && !wide && x + fw <= img_w_eff && y + fh <= img_h_eff) begin
        for (int r = y; r < y + fh; r++)
          for (int c = x; c < x + fw; c++)
            paint(c, r);
      end
    end
  endtask

  task automatic drain_engine();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[DIM_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input int w, h, input bit mode);
    drain_engine();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    // only bit 0 counts; the rest is junk
    write_reg(REG_PIXEL_MODE, 32'({9'($urandom_range(0, 511)), mode}));
    img_w_eff = visible(w);
    img_h_eff = visible(h);
    wide = mode;
    foreach (painted_map[i]) painted_map[i] = '0;
    painted.delete();
  endtask

  task automatic random_command();
    int pick, x, y, fw, fh, cap;
    logic [OP_W-1:0] op;
    spot_t spot;
    pick = $urandom_range(0, 99);
    x = $urandom_range(0, img_w_eff - 1);
    y = $urandom_range(0, img_h_eff - 1);
    if (pick < 25 && painted.size() > 0) begin
      spot = painted[$urandom_range(0, painted.size() - 1)];
      issue(OP_GET, spot.x, spot.y, PIX_W'($urandom), $urandom_range(0, 1023),
            $urandom_range(0, 1023));
    end else if (pick < 70) begin
      if ($urandom_range(0, 4) == 0) x = img_w_eff - 1;
      if ($urandom_range(0, 4) == 0) y = img_h_eff - 1;
      issue(OP_PUT, x, y, PIX_W'($urandom), $urandom_range(0, 1023),
            $urandom_range(0, 1023));
    end else if (pick < 90) begin
      // mostly small rectangles, now and then a larger one or an overrun
      cap = ($urandom_range(0, 19) == 0) ? 64 : 8;
      fw = $urandom_range(0, (img_w_eff - x < cap) ? img_w_eff - x : cap);
      fh = $urandom_range(0, (img_h_eff - y < cap) ? img_h_eff - y : cap);
      case ($urandom_range(0, 9))
        0: fw = img_w_eff - x + $urandom_range(1, 4);
        1: fh = img_h_eff - y + $urandom_range(1, 4);
        default: ;
      endcase
      issue(OP_FILL, x, y, PIX_W'($urandom), fw, fh);
    end else begin
      op = OP_W'($urandom_range(OP_PUT, OP_UNKNOWN));
      x = $urandom_range(0, 511);
      y = $urandom_range(0, 511);
      fw = $urandom_range(0, 1023);
      fh = $urandom_range(0, 1023);
      if (op == OP_GET && x < img_w_eff && y < img_h_eff && !painted_map[y][x])
        op = OP_PUT;
      // a tall rectangle is always refused, by position or overrun, keeping walks short
      if (op == OP_FILL && fw * fh > 4096) fh = 1023;
      issue(op, x, y, PIX_W'($urandom), fw, fh);
    end
  endtask

  int ph_w[8]    = '{4, 7, 512, 0, 1023, 13, 0, 37};
  int ph_h[8]    = '{4, 5, 512, 2, 1023, 600, 0, 9};
  bit ph_mode[8] = '{0, 1, 1, 0, 0, 1, 0, 0};

  initial begin
    foreach (painted_map[i]) painted_map[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset setup: 4 x 4, one byte per pixel
    issue(OP_PUT, 0, 0, 24'h000000, 0, 0);
    issue(OP_PUT, 3, 3, 24'hFFFFFF, 1023, 1023);
    issue(OP_GET, 0, 0, 24'h000000, 0, 0);
    issue(OP_GET, 3, 3, 24'hFFFFFF, 1023, 1023);
    issue(OP_PUT, 4, 0, 24'h123456, 0, 0);
    issue(OP_GET, 0, 4, 24'h000000, 0, 0);
    issue(OP_GET, 511, 511, 24'h000000, 0, 0);
    issue(OP_UNKNOWN, 1, 1, 24'hFFFFFF, 1, 1);
    issue(OP_FILL, 1, 1, 24'h0000AA, 0, 3);
    issue(OP_FILL, 1, 1, 24'h0000AA, 3, 0);
    issue(OP_FILL, 2, 0, 24'h0000AA, 3, 1);
    issue(OP_FILL, 0, 0, 24'h0000AA, 1023, 1023);
    issue(OP_FILL, 5, 0, 24'h0000AA, 0, 0);
    issue(OP_FILL, 0, 0, 24'h5A5A81, 4, 4);
    issue(OP_GET, 2, 1, 24'h000000, 0, 0);

    configure(512, 512, 1'b0);
    issue(OP_PUT, 511, 511, 24'h0000AB, 0, 0);
    issue(OP_GET, 511, 511, 24'h000000, 0, 0);
    issue(OP_FILL, 0, 0, 24'hC3C33C, 512, 512);
    issue(OP_GET, 511, 0, 24'h000000, 0, 0);
    issue(OP_GET, 0, 511, 24'h000000, 0, 0);

    configure(512, 512, 1'b1);
    issue(OP_PUT, 511, 0, 24'hF0C3A5, 0, 0);
    issue(OP_GET, 511, 0, 24'h000000, 0, 0);
    issue(OP_FILL, 0, 0, 24'h000011, 1, 1);
    issue(OP_FILL, 511, 511, 24'h000011, 2, 1);
    issue(OP_FILL, 0, 0, 24'h000011, 0, 0);

    ph_w[6] = $urandom_range(4, 40);
    ph_h[6] = $urandom_range(4, 40);
    ph_mode[6] = 1'($urandom_range(0, 1));
    for (int p = 0; p < 8; p++) begin
      configure(ph_w[p], ph_h[p], ph_mode[p]);
      if (p == 3) write_reg(REG_SPARE, $urandom_range(0, 1023));
      for (int i = 0; i < 250; i++) begin
        // stretches with and without idling; none at all in the last setup
        if (i % 40 == 0) idling = (p != 7) && ($urandom_range(0, 3) != 0);
        random_command();
      end
    end

    drain_engine();
    if (mismatches == 0 && pending == 0)
      $display("bottom_up_framebuffer_pixel_engine verification clean");
    else
      $display("bottom_up_framebuffer_pixel_engine verification failed");
    $finish;
  end

endmodule
